### rtl/core/lennard_jones_pair_energy_sum_assert.svh
// Assertion macros for the Lennard-Jones pair energy block
`ifndef LENNARD_JONES_PAIR_ENERGY_SUM_ASSERT_SVH
`define LENNARD_JONES_PAIR_ENERGY_SUM_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset
`define LJES_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ljes check failed");
// Check that a trigger is followed by a condition on the next edge
`define LJES_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ljes sequence check failed");
`else
`define LJES_CHECK(label, clk, rst_n, prop)
`define LJES_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/ljes_pkg.sv
// Shared constants for the Lennard-Jones pair energy block
`timescale 1ns / 1ps
package ljes_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INTER_BITS      = 24;
    // quotient bits kept by the reciprocal; larger values saturate
    localparam int INV_BITS        = 29;
    localparam int ACC_W           = 48;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int BOX_W           = 31;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [BOX_W-1:0] BOX_WIDTH_RST  = 31'd65536000;
    localparam logic [BOX_W-1:0] BOX_HEIGHT_RST = 31'd65536000;
    localparam logic [BOX_W-1:0] CUTOFF_SQ_RST  = 31'd589824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_WIDTH    = 2'd0,
        REG_BOX_HEIGHT   = 2'd1,
        REG_CUTOFF_SQ    = 2'd2,
        REG_ENERGY_SHIFT = 2'd3
    } t_reg_idx;
endpackage

### rtl/core/ljes_pair_if.sv
// Input channel carrying one atom pair per beat
`timescale 1ns / 1ps
interface ljes_pair_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic                          last_pair;
    modport source (output valid, first_x, first_y, second_x, second_y, last_pair,
                    input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, last_pair,
                    output ready);
endinterface

### rtl/core/ljes_sum_if.sv
// Output channel carrying one energy sum per beat
`timescale 1ns / 1ps
interface ljes_sum_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] energy_sum;
    logic               saturated;
    modport source (output valid, energy_sum, saturated, input ready);
    modport sink   (input valid, energy_sum, saturated, output ready);
endinterface

### rtl/core/lennard_jones_pair_energy_sum.sv
// Lennard-Jones pair energy accumulator around one shared multiplier
//
//  channel  | dir | handshake   | beat
//  i_pair   | in  | valid/ready | first_x, first_y, second_x, second_y, last_pair
//  o_sum    | out | valid/ready | energy_sum, saturated
//  i_cfg_*  | in  | write only  | index, data
//
// A counted pair passes through five 40x40 products on a 40x20 multiplier (low
// digit, then high digit, each), a 29-step restoring reciprocal divider and five
// one-state steps. Pairs beyond the 2^31 range go from the fold straight to the
// sum step; pairs outside the cutoff or too close to divide go there from the compare.
// Reset is synchronous; it restores the register defaults and clears the sum.
// A sum beat waits in the output register; a new pair is taken meanwhile and
// stalls only when its own sum is ready before the previous one leaves.
`timescale 1ns / 1ps
`include "lennard_jones_pair_energy_sum_assert.svh"
module lennard_jones_pair_energy_sum
    import ljes_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ljes_pair_if.sink            i_pair,
    ljes_sum_if.source           o_sum
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int FW   = ((DW > BOX_W + 1) ? DW : BOX_W + 1) + 2;
    localparam int MW   = 40;
    localparam int DIGW = MW / 2;
    localparam int PW   = 2 * MW;
    localparam int SQW  = 2 * BOX_W;
    localparam int R2W  = SQW + 1 - FRAC_BITS;
    localparam int SH   = INTER_BITS - FRAC_BITS;
    localparam int U2W  = 55;
    localparam int LW   = U2W + 5;
    localparam int CW   = $clog2(INV_BITS);
    // largest r^2 whose reciprocal no longer fits the quotient
    localparam logic [R2W-1:0] SAT_R2 = R2W'(1) << (FRAC_BITS + INTER_BITS - INV_BITS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FOLD, ST_SQX, ST_SQY, ST_CMP, ST_DIV,
        ST_M1, ST_M2, ST_M3, ST_FIN, ST_ACC
    } t_state;

    t_state                  r_state;
    logic                    r_half;
    logic                    r_last;
    logic signed [DW-1:0]    r_dx, r_dy;
    logic [MW-1:0]           r_mul_a, r_mul_b;
    logic [PW-1:0]           r_prod;
    logic [SQW-1:0]          r_sq;
    logic [R2W-1:0]          r_r2;
    logic [BOX_W:0]          r_rem;
    logic [INV_BITS-1:0]     r_q;
    logic [CW-1:0]           r_cnt;
    logic [MW-1:0]           r_u;
    logic [U2W-1:0]          r_u2;
    logic [ACC_W-1:0]        r_val;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_sat;
    logic                    r_out_valid;
    logic [ACC_W-1:0]        r_out_sum;
    logic                    r_out_sat;
    logic [BOX_W-1:0]        r_box_w, r_box_h, r_cut;
    logic signed [CFG_W-1:0] r_shift;

    logic [DIGW-1:0]         n_digit;
    logic [MW+DIGW-1:0]      n_part;
    logic [PW-1:0]           n_prod;
    logic signed [FW-1:0]    n_fx, n_fy;
    logic [FW-1:0]           n_ax, n_ay;
    logic                    n_far;
    logic [SQW:0]            n_r2sum;
    logic [BOX_W:0]          n_trial;
    logic                    n_qbit;
    logic [BOX_W:0]          n_rem;
    logic [INV_BITS-1:0]     n_q;
    logic signed [LW-1:0]    n_lj;
    logic signed [LW:0]      n_value;
    logic [ACC_W-1:0]        n_value_c;
    logic                    n_value_sat;
    logic signed [ACC_W:0]   n_acc_sum;
    logic [ACC_W-1:0]        n_acc;
    logic                    n_acc_sat;
    logic                    n_out_free;

    // Fold one displacement onto the nearest periodic image
    function automatic logic signed [FW-1:0] fold(input logic signed [DW-1:0] d,
                                                   input logic [BOX_W-1:0] box);
        logic signed [FW-1:0] de, be, he;
        de = FW'(d);
        be = $signed({{(FW-BOX_W){1'b0}}, box});
        he = $signed({{(FW-BOX_W+1){1'b0}}, box[BOX_W-1:1]});
        if (de > he)
            fold = de - be;
        else if (de < -he)
            fold = de + be;
        else
            fold = de;
    endfunction

    // Shared multiplier: low digit, then high digit shifted in
    always_comb begin
        n_digit = r_half ? r_mul_b[MW-1:DIGW] : r_mul_b[DIGW-1:0];
        n_part  = r_mul_a * n_digit;
        if (r_half)
            n_prod = r_prod + {n_part, {DIGW{1'b0}}};
        else
            n_prod = PW'(n_part);
    end

    // Fold, magnitude and range check
    always_comb begin
        n_fx  = fold(r_dx, r_box_w);
        n_fy  = fold(r_dy, r_box_h);
        n_ax  = n_fx[FW-1] ? FW'(-n_fx) : FW'(n_fx);
        n_ay  = n_fy[FW-1] ? FW'(-n_fy) : FW'(n_fy);
        n_far = (|n_ax[FW-1:BOX_W]) || (|n_ay[FW-1:BOX_W]);
        n_r2sum = {1'b0, r_sq} + {1'b0, n_prod[SQW-1:0]};
    end

    // One restoring divider step
    always_comb begin
        n_trial = {r_rem[BOX_W-1:0], 1'b0};
        n_qbit  = n_trial >= {1'b0, r_r2[BOX_W-1:0]};
        n_rem   = n_qbit ? n_trial - {1'b0, r_r2[BOX_W-1:0]} : n_trial;
        n_q     = {r_q[INV_BITS-2:0], n_qbit};
    end

    // Pair value: 4*(u2 - u) scaled down, plus shift, clamped; clamped accumulator add
    always_comb begin
        n_lj = ($signed({5'b0, r_u2}) - $signed({{(LW-MW){1'b0}}, r_u})) <<< 2;
        n_lj = n_lj >>> SH;
        n_value = LW'(n_lj) + (LW+1)'(r_shift);
        n_value_sat = (n_value[LW:ACC_W-1] != {(LW-ACC_W+2){1'b0}}) &&
                      (n_value[LW:ACC_W-1] != {(LW-ACC_W+2){1'b1}});
        if (n_value_sat)
            n_value_c = n_value[LW] ? ACC_MIN : ACC_MAX;
        else
            n_value_c = n_value[ACC_W-1:0];
        n_acc_sum = $signed({r_acc[ACC_W-1], r_acc}) + $signed({r_val[ACC_W-1], r_val});
        n_acc_sat = n_acc_sum[ACC_W] != n_acc_sum[ACC_W-1];
        if (n_acc_sat)
            n_acc = n_acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            n_acc = n_acc_sum[ACC_W-1:0];
        n_out_free = !r_out_valid || o_sum.ready;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= BOX_WIDTH_RST;
            r_box_h <= BOX_HEIGHT_RST;
            r_cut   <= CUTOFF_SQ_RST;
            r_shift <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_WIDTH:    r_box_w <= i_cfg_data[BOX_W-1:0];
                REG_BOX_HEIGHT:   r_box_h <= i_cfg_data[BOX_W-1:0];
                REG_CUTOFF_SQ:    r_cut   <= i_cfg_data[BOX_W-1:0];
                REG_ENERGY_SHIFT: r_shift <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_half      <= 1'b0;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a sum beat, or drop the one taken by the sink
            if (r_state == ST_ACC && r_last && n_out_free)
                r_out_valid <= 1'b1;
            else if (o_sum.ready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_pair.valid) begin
                        r_dx    <= DW'(i_pair.second_x) - DW'(i_pair.first_x);
                        r_dy    <= DW'(i_pair.second_y) - DW'(i_pair.first_y);
                        r_last  <= i_pair.last_pair;
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (n_far) begin
                        r_val   <= '0;
                        r_state <= ST_ACC;
                    end else begin
                        r_mul_a <= MW'(n_ax[BOX_W-1:0]);
                        r_mul_b <= MW'(n_ax[BOX_W-1:0]);
                        r_half  <= 1'b0;
                        r_state <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    r_prod <= n_prod;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_sq    <= n_prod[SQW-1:0];
                        r_mul_a <= MW'(n_ay[BOX_W-1:0]);
                        r_mul_b <= MW'(n_ay[BOX_W-1:0]);
                        r_state <= ST_SQY;
                    end
                end
                ST_SQY: begin
                    r_prod <= n_prod;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_r2    <= n_r2sum[SQW:FRAC_BITS];
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (r_r2 > R2W'(r_cut)) begin
                        r_val   <= '0;
                        r_state <= ST_ACC;
                    end else if (r_r2 <= SAT_R2) begin
                        r_val   <= ACC_MAX;
                        r_sat   <= 1'b1;
                        r_state <= ST_ACC;
                    end else begin
                        r_rem   <= (BOX_W+1)'(SAT_R2);
                        r_q     <= '0;
                        r_cnt   <= CW'(INV_BITS - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_mul_a <= MW'(n_q);
                        r_mul_b <= MW'(n_q);
                        r_half  <= 1'b0;
                        r_state <= ST_M1;
                    end
                end
                ST_M1: begin
                    r_prod <= n_prod;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_mul_a <= n_prod[INTER_BITS+MW-1:INTER_BITS];
                        r_mul_b <= MW'(r_q);
                        r_state <= ST_M2;
                    end
                end
                ST_M2: begin
                    r_prod <= n_prod;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_u     <= n_prod[INTER_BITS+MW-1:INTER_BITS];
                        r_mul_a <= n_prod[INTER_BITS+MW-1:INTER_BITS];
                        r_mul_b <= n_prod[INTER_BITS+MW-1:INTER_BITS];
                        r_state <= ST_M3;
                    end
                end
                ST_M3: begin
                    r_prod <= n_prod;
                    r_half <= !r_half;
                    if (r_half) begin
                        r_u2    <= n_prod[INTER_BITS+U2W-1:INTER_BITS];
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_val <= n_value_c;
                    if (n_value_sat)
                        r_sat <= 1'b1;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (!r_last) begin
                        r_acc   <= n_acc;
                        r_sat   <= r_sat | n_acc_sat;
                        r_state <= ST_IDLE;
                    end else if (n_out_free) begin
                        r_out_sum   <= n_acc;
                        r_out_sat   <= r_sat | n_acc_sat;
                        r_acc       <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_pair.ready     = (r_state == ST_IDLE);
    assign o_sum.valid      = r_out_valid;
    assign o_sum.energy_sum = $signed(r_out_sum);
    assign o_sum.saturated  = r_out_sat;

    // Checks on the sequencer and divider
    `LJES_CHECK_NEXT(a_accept_starts, i_clk, i_rst_n, i_pair.valid && i_pair.ready, r_state == ST_FOLD)
    `LJES_CHECK(a_div_rem_bound, i_clk, i_rst_n, (r_state != ST_DIV) || (r_rem < {1'b0, r_r2[BOX_W-1:0]}))
    `LJES_CHECK(a_sum_from_last, i_clk, i_rst_n, !$rose(o_sum.valid) || $past(r_state == ST_ACC && r_last))
endmodule
